FILE: src/pmic_power_sequencer_core_assert.svh
// assertion macros for the power sequencer core
// needs a clock named clk and an active-low reset named arst_n in the using module
`ifndef PMIC_POWER_SEQUENCER_CORE_ASSERT_SVH
`define PMIC_POWER_SEQUENCER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PSQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("power sequencer assertion failed");
// next-cycle implication
`define PSQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("power sequencer assertion failed");
`else
`define PSQ_ASSERT_NOW(lbl, ante, cons)
`define PSQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/psq_pkg.sv
// shared types and codes for the power sequencer core
// no dependencies
package psq_pkg;

	// power state codes
	localparam logic [2:0] ST_INITIAL = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_UP      = 3'd2;
	localparam logic [2:0] ST_DOWN    = 3'd3;
	localparam logic [2:0] ST_RESET   = 3'd4;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_SET   = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;
	localparam logic [1:0] CMD_NONE  = 2'd3;

	typedef struct packed {
		logic [15:0] delay_ticks;
		logic [15:0] strobe_high_ticks;
		logic [15:0] hold_wait_ticks;
		logic [15:0] reset_wait_ticks;
		logic [7:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic boot;
		logic rev;
		logic chip;
		logic strobe;
		logic disp;
	} pins_t;

	typedef struct packed {
		logic [2:0] power_state;
		logic [2:0] step;
		logic [7:0] retry_count;
		logic       min_flag;
		pins_t      pins;
	} seq_state_t;

endpackage

FILE: src/psq_cfg_regs.sv
// configuration register file of the power sequencer
// depends on psq_pkg
module psq_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [15:0]      cfg_wdata,
	output psq_pkg::cfg_t    cfg
);
	import psq_pkg::*;

	localparam logic [2:0] REG_DELAY  = 3'd0;
	localparam logic [2:0] REG_STROBE = 3'd1;
	localparam logic [2:0] REG_HOLD   = 3'd2;
	localparam logic [2:0] REG_RWAIT  = 3'd3;
	localparam logic [2:0] REG_RETRY  = 3'd4;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks       <= 16'd5;
			cfg_q.strobe_high_ticks <= 16'd3;
			cfg_q.hold_wait_ticks   <= 16'd100;
			cfg_q.reset_wait_ticks  <= 16'd400;
			cfg_q.retry_limit       <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_DELAY:  cfg_q.delay_ticks       <= cfg_wdata;
				REG_STROBE: cfg_q.strobe_high_ticks <= cfg_wdata;
				REG_HOLD:   cfg_q.hold_wait_ticks   <= cfg_wdata;
				REG_RWAIT:  cfg_q.reset_wait_ticks  <= cfg_wdata;
				REG_RETRY:  cfg_q.retry_limit       <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/psq_step.sv
// next-state logic of the power sequencer for one command
// depends on psq_pkg
module psq_step #(
	parameter int CNT_W = 16
) (
	input  psq_pkg::cfg_t       cfg,
	input  psq_pkg::seq_state_t cur,
	input  logic [CNT_W-1:0]    tick_cur,
	input  logic [1:0]          cmd,
	input  logic                hold_level,
	input  logic [2:0]          req_state,
	input  logic                min_system,
	input  logic                main_power_on,
	output psq_pkg::seq_state_t nxt,
	output logic [CNT_W-1:0]    tick_nxt,
	output logic                irq_event,
	output logic                timed_out,
	output logic                accepted
);
	import psq_pkg::*;

	localparam int CW = (CNT_W > 16) ? CNT_W : 16;

	// power-up steps
	localparam logic [2:0] UP_ENABLE = 3'd0;
	localparam logic [2:0] UP_DELAY  = 3'd1;
	localparam logic [2:0] UP_STROBE = 3'd2;
	localparam logic [2:0] UP_HOLD   = 3'd3;
	localparam logic [2:0] UP_DONE   = 3'd4;
	// reset steps
	localparam logic [2:0] RS_RAILS   = 3'd0;
	localparam logic [2:0] RS_PINS    = 3'd1;
	localparam logic [2:0] RS_WAIT    = 3'd2;
	localparam logic [2:0] RS_RESTART = 3'd3;
	// step left behind by power-down
	localparam logic [2:0] DN_DONE    = 3'd1;

	logic [CNT_W-1:0] tick_inc;
	logic [CW-1:0]    inc_w;
	logic [7:0]       retry_inc;

	// saturating increments
	assign tick_inc  = (&tick_cur) ? tick_cur : tick_cur + CNT_W'(1);
	assign inc_w     = CW'(tick_inc);
	assign retry_inc = (&cur.retry_count) ? cur.retry_count : cur.retry_count + 8'd1;

	always_comb begin
		nxt       = cur;
		tick_nxt  = tick_cur;
		irq_event = 1'b0;
		timed_out = 1'b0;
		accepted  = 1'b0;
		case (cmd)
			CMD_TICK: begin
				accepted = 1'b1;
				case (cur.power_state)
					ST_UP: begin
						case (cur.step)
							UP_ENABLE: begin
								nxt.pins.disp   = 1'b1;
								nxt.pins.strobe = 1'b0;
								nxt.pins.chip   = 1'b1;
								nxt.pins.rev    = 1'b1;
								nxt.step        = UP_DELAY;
								tick_nxt        = '0;
							end
							UP_DELAY: begin
								tick_nxt = tick_inc;
								if (inc_w >= CW'(cfg.delay_ticks)) begin
									tick_nxt        = '0;
									nxt.step        = UP_STROBE;
									nxt.pins.strobe = 1'b1;
								end
							end
							UP_STROBE: begin
								tick_nxt = tick_inc;
								if (inc_w >= CW'(cfg.strobe_high_ticks)) begin
									tick_nxt        = '0;
									nxt.step        = UP_HOLD;
									nxt.pins.strobe = 1'b0;
								end
							end
							UP_HOLD: begin
								if (!hold_level) begin
									tick_nxt = tick_inc;
									if (inc_w >= CW'(cfg.hold_wait_ticks)) begin
										nxt.retry_count = retry_inc;
										tick_nxt        = '0;
										if (retry_inc >= cfg.retry_limit) begin
											nxt.step  = UP_DONE;
											timed_out = 1'b1;
										end else begin
											nxt.pins.strobe = 1'b0;
											nxt.pins.chip   = 1'b0;
											nxt.step        = UP_ENABLE;
										end
									end
								end else begin
									nxt.step        = UP_DONE;
									tick_nxt        = '0;
									nxt.retry_count = '0;
								end
							end
							UP_DONE: begin
								irq_event       = 1'b1;
								nxt.power_state = ST_IDLE;
							end
							default: begin
							end
						endcase
					end
					ST_DOWN: begin
						nxt.pins.strobe = 1'b0;
						nxt.pins.chip   = 1'b0;
						nxt.step        = DN_DONE;
						nxt.power_state = ST_IDLE;
						nxt.retry_count = '0;
					end
					ST_RESET: begin
						case (cur.step)
							RS_RAILS: begin
								nxt.pins.disp = 1'b0;
								nxt.step      = RS_PINS;
							end
							RS_PINS: begin
								nxt.pins.strobe = 1'b0;
								nxt.pins.chip   = 1'b0;
								nxt.pins.boot   = cur.min_flag;
								tick_nxt        = '0;
								nxt.retry_count = '0;
								nxt.step        = RS_WAIT;
							end
							RS_WAIT: begin
								tick_nxt = tick_inc;
								if (inc_w > CW'(cfg.reset_wait_ticks)) begin
									nxt.step = RS_RESTART;
								end
							end
							RS_RESTART: begin
								tick_nxt        = '0;
								nxt.step        = UP_ENABLE;
								nxt.power_state = ST_UP;
								nxt.min_flag    = 1'b0;
							end
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
			CMD_SET: begin
				accepted = 1'b1;
				if (req_state <= ST_RESET) begin
					tick_nxt        = '0;
					nxt.step        = '0;
					nxt.power_state = req_state;
					nxt.min_flag    = 1'b0;
				end
			end
			CMD_RESET: begin
				if (cur.power_state == ST_IDLE && main_power_on) begin
					tick_nxt        = '0;
					nxt.step        = '0;
					nxt.power_state = ST_RESET;
					nxt.min_flag    = min_system;
					accepted        = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: src/pmic_power_sequencer_core.sv
// power sequencer core: a transaction passes the input stage, then the result register, on
// its way to the master side; throughput one transaction per cycle while m_tready takes
// results; the state update is a single pass of psq_step between these two registers, with no stall of its own
// arst_n clears the sequencer to the initial state with all pins low and loads
// the configuration defaults; both stream stages come out of reset empty
`include "pmic_power_sequencer_core_assert.svh"
module pmic_power_sequencer_core #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // hold_level, req_state[2:0], min_system, main_power_on, 2'b0
	input  logic [1:0]  s_tuser,   // cmd
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // display_enable, strobe_level, chip_enable, reverse_irq,
	                               // boot_mode_pin, irq_enable_event, state_now[2:0],
	                               // timed_out, accepted, 5'b0
);
	import psq_pkg::*;

	localparam int W = TICK_COUNT_WIDTH;

	// input stage
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic       hold_s1;
	logic [2:0] req_s1;
	logic       min_s1;
	logic       main_s1;

	// sequencer state
	seq_state_t   state_q;
	logic [W-1:0] tick_q;

	// result register
	logic        out_valid_q;
	logic [15:0] out_data_q;

	cfg_t         cfg;
	seq_state_t   state_nxt;
	logic [W-1:0] tick_nxt;
	logic         irq_event;
	logic         timed_out;
	logic         accepted;
	logic         adv;

	// the input stage moves on whenever the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	psq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	psq_step #(
		.CNT_W (W)
	) u_step (
		.cfg           (cfg),
		.cur           (state_q),
		.tick_cur      (tick_q),
		.cmd           (cmd_s1),
		.hold_level    (hold_s1),
		.req_state     (req_s1),
		.min_system    (min_s1),
		.main_power_on (main_s1),
		.nxt           (state_nxt),
		.tick_nxt      (tick_nxt),
		.irq_event     (irq_event),
		.timed_out     (timed_out),
		.accepted      (accepted)
	);

	// control: stage valids and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
			tick_q      <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
				tick_q      <= tick_nxt;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: unpack the command transaction
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			hold_s1 <= s_tdata[0];
			req_s1  <= s_tdata[3:1];
			min_s1  <= s_tdata[4];
			main_s1 <= s_tdata[5];
		end
	end

	// payload: pin levels are reported after the update
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {5'b0, accepted, timed_out, state_nxt.power_state, irq_event,
				state_nxt.pins.boot, state_nxt.pins.rev, state_nxt.pins.chip,
				state_nxt.pins.strobe, state_nxt.pins.disp};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// power-up only ends by going idle
	`PSQ_ASSERT_NOW(a_irq_idle, out_valid_q && out_data_q[5], out_data_q[8:6] == ST_IDLE)
	// a timeout and the end of power-up never share a transaction
	`PSQ_ASSERT_NOW(a_irq_tmo_excl, out_valid_q, !(out_data_q[5] && out_data_q[9]))
	// ticks and set requests are always taken
	`PSQ_ASSERT_NEXT(a_tick_set_acc, adv && (cmd_s1 == CMD_TICK || cmd_s1 == CMD_SET),
		out_data_q[10])
	// a valid set request restarts the counter
	`PSQ_ASSERT_NEXT(a_set_clears, adv && cmd_s1 == CMD_SET && req_s1 <= ST_RESET,
		tick_q == '0 && state_q.step == 3'd0)

endmodule

FILE: tb/sv/psq_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the power sequencer testbench: a cycle-free model of the
// sequencer that forecasts each result, plus the queue of forecasts; needs psq_pkg
package psq_tb_pkg;
	import psq_pkg::*;

	localparam int TB_TICK_WIDTH = 16;

	// configuration register indexes
	localparam logic [2:0] REG_DELAY       = 3'd0;
	localparam logic [2:0] REG_STROBE_HIGH = 3'd1;
	localparam logic [2:0] REG_HOLD_WAIT   = 3'd2;
	localparam logic [2:0] REG_RESET_WAIT  = 3'd3;
	localparam logic [2:0] REG_RETRY_LIMIT = 3'd4;

	// power-up steps
	localparam logic [2:0] UP_RAILS  = 3'd0;
	localparam logic [2:0] UP_DELAY  = 3'd1;
	localparam logic [2:0] UP_STROBE = 3'd2;
	localparam logic [2:0] UP_HOLD   = 3'd3;
	localparam logic [2:0] UP_DONE   = 3'd4;

	// reset steps
	localparam logic [2:0] RST_RAILS   = 3'd0;
	localparam logic [2:0] RST_PINS    = 3'd1;
	localparam logic [2:0] RST_WAIT    = 3'd2;
	localparam logic [2:0] RST_RESTART = 3'd3;

	// result layout, disp in bit 0
	typedef struct packed {
		logic       accepted;
		logic       timed_out;
		logic [2:0] state_now;
		logic       irq_event;
		logic       boot;
		logic       rev;
		logic       chip;
		logic       strobe;
		logic       disp;
	} seq_result_t;

	class psq_scoreboard;
		cfg_t                     cfg;
		logic [2:0]               power_state;
		logic [2:0]               step;
		logic [TB_TICK_WIDTH-1:0] tick_count;
		logic [7:0]               retry_count;
		logic                     min_flag;
		pins_t                    pins;
		seq_result_t              due_outputs[$];
		int unsigned              n_errors, n_sent, n_checked;
		int unsigned              n_timeouts, n_irq, n_resets_taken;

		function new();
			cfg = '{16'd5, 16'd3, 16'd100, 16'd400, 8'd3};
			power_state = ST_INITIAL;
			step = '0;
			tick_count = '0;
			retry_count = '0;
			min_flag = 1'b0;
			pins = '0;
		endfunction

		function int pending();
			return due_outputs.size();
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_DELAY:       cfg.delay_ticks = val;
				REG_STROBE_HIGH: cfg.strobe_high_ticks = val;
				REG_HOLD_WAIT:   cfg.hold_wait_ticks = val;
				REG_RESET_WAIT:  cfg.reset_wait_ticks = val;
				REG_RETRY_LIMIT: cfg.retry_limit = val[7:0];
				default: ;
			endcase
		endfunction

		function void count_up();
			if (tick_count != '1)
				tick_count++;
		endfunction

		function void step_power_up(logic hold, output logic irq_ev, output logic tmo);
			irq_ev = 1'b0;
			tmo = 1'b0;
			case (step)
				UP_RAILS: begin
					pins.disp = 1'b1;
					pins.strobe = 1'b0;
					pins.chip = 1'b1;
					pins.rev = 1'b1;
					step = UP_DELAY;
					tick_count = '0;
				end
				UP_DELAY: begin
					count_up();
					if (tick_count >= cfg.delay_ticks) begin
						tick_count = '0;
						step = UP_STROBE;
						pins.strobe = 1'b1;
					end
				end
				UP_STROBE: begin
					count_up();
					if (tick_count >= cfg.strobe_high_ticks) begin
						step = UP_HOLD;
						tick_count = '0;
						pins.strobe = 1'b0;
					end
				end
				UP_HOLD: begin
					if (!hold) begin
						count_up();
						if (tick_count >= cfg.hold_wait_ticks) begin
							if (retry_count != 8'hFF)
								retry_count++;
							tick_count = '0;
							if (retry_count >= cfg.retry_limit) begin
								step = UP_DONE;
								tmo = 1'b1;
							end else begin
								pins.strobe = 1'b0;
								pins.chip = 1'b0;
								step = UP_RAILS;
							end
						end
					end else begin
						step = UP_DONE;
						tick_count = '0;
						retry_count = '0;
					end
				end
				UP_DONE: begin
					irq_ev = 1'b1;
					power_state = ST_IDLE;
				end
				default: ;
			endcase
		endfunction

		function void step_reset();
			case (step)
				RST_RAILS: begin
					pins.disp = 1'b0;
					step = RST_PINS;
				end
				RST_PINS: begin
					pins.strobe = 1'b0;
					pins.chip = 1'b0;
					pins.boot = min_flag;
					tick_count = '0;
					retry_count = '0;
					step = RST_WAIT;
				end
				RST_WAIT: begin
					count_up();
					if (tick_count > cfg.reset_wait_ticks)
						step = RST_RESTART;
				end
				RST_RESTART: begin
					tick_count = '0;
					step = UP_RAILS;
					power_state = ST_UP;
					min_flag = 1'b0;
				end
				default: ;
			endcase
		endfunction

		// forecast the result of one accepted command
		function void note_command(logic [1:0] cmd, logic [7:0] data);
			seq_result_t r;
			logic        hold, min_sys, main_on, irq_ev, tmo;
			logic [2:0]  req;
			hold = data[0];
			req = data[3:1];
			min_sys = data[4];
			main_on = data[5];
			r = '0;
			irq_ev = 1'b0;
			tmo = 1'b0;
			n_sent++;
			case (cmd)
				CMD_TICK: begin
					r.accepted = 1'b1;
					case (power_state)
						ST_UP: step_power_up(hold, irq_ev, tmo);
						ST_DOWN: begin
							pins.strobe = 1'b0;
							pins.chip = 1'b0;
							// step value is dead here: leaving idle clears it
							step = UP_DELAY;
							power_state = ST_IDLE;
							retry_count = '0;
						end
						ST_RESET: step_reset();
						default: ;
					endcase
				end
				CMD_SET: begin
					r.accepted = 1'b1;
					if (req <= ST_RESET) begin
						tick_count = '0;
						step = '0;
						power_state = req;
						min_flag = 1'b0;
					end
				end
				CMD_RESET: begin
					if (power_state == ST_IDLE && main_on) begin
						tick_count = '0;
						step = '0;
						power_state = ST_RESET;
						min_flag = min_sys;
						r.accepted = 1'b1;
						n_resets_taken++;
					end
				end
				default: ;
			endcase
			r.disp = pins.disp;
			r.strobe = pins.strobe;
			r.chip = pins.chip;
			r.rev = pins.rev;
			r.boot = pins.boot;
			r.irq_event = irq_ev;
			r.state_now = power_state;
			r.timed_out = tmo;
			n_timeouts += tmo;
			n_irq += irq_ev;
			due_outputs.push_back(r);
		endfunction

		task report(string what, int got, int want);
			n_errors++;
			$display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
		endtask

		task check_output(logic [15:0] data);
			seq_result_t got, want;
			got = data[10:0];
			if (due_outputs.size() == 0) begin
				report("result with nothing outstanding", data, 0);
			end else begin
				want = due_outputs.pop_front();
				if (got.disp !== want.disp)
					report("display_enable", got.disp, want.disp);
				if (got.strobe !== want.strobe)
					report("strobe_level", got.strobe, want.strobe);
				if (got.chip !== want.chip)
					report("chip_enable", got.chip, want.chip);
				if (got.rev !== want.rev)
					report("reverse_irq", got.rev, want.rev);
				if (got.boot !== want.boot)
					report("boot_mode_pin", got.boot, want.boot);
				if (got.irq_event !== want.irq_event)
					report("irq_enable_event", got.irq_event, want.irq_event);
				if (got.state_now !== want.state_now)
					report("state_now", got.state_now, want.state_now);
				if (got.timed_out !== want.timed_out)
					report("timed_out", got.timed_out, want.timed_out);
				if (got.accepted !== want.accepted)
					report("accepted", got.accepted, want.accepted);
				if (data[15:11] !== 5'b0)
					report("padding", data[15:11], 0);
			end
			n_checked++;
		endtask
	endclass

endpackage

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the power sequencer testbench: clock, reset, command and result drivers
// and the stall watchdog; needs psq_pkg, psq_tb_pkg and the sequencer core
module tb_top;
	import psq_pkg::*;
	import psq_tb_pkg::*;

	// cycles with no transaction on either side before the run is abandoned;
	// the longest correct quiet stretch is the long receiver hold-off
	localparam int STALL_LIMIT  = 4000;
	localparam int LONG_HOLDOFF = 200;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_addr  = '0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // hold_level, req_state[2:0], min_system, main_power_on, 2'b0
	logic [1:0]  s_tuser   = '0;   // cmd
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // display_enable, strobe_level, chip_enable, reverse_irq,
	                               // boot_mode_pin, irq_enable_event, state_now[2:0],
	                               // timed_out, accepted, 5'b0

	psq_scoreboard sb = new();

	// idling controls of the stimulus and the result side, and the count of register settings
	int          send_idle_pct    = 0;
	int          recv_idle_pct    = 0;
	bit          quiet            = 1'b0;
	bit          long_holdoff_req = 1'b0;
	int unsigned n_settings       = 0;

	pmic_power_sequencer_core #(
		.TICK_COUNT_WIDTH(TB_TICK_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] pack_cmd(logic hold, logic [2:0] req, logic min_sys,
			logic main_on);
		return {2'b00, main_on, min_sys, req, hold};
	endfunction

	function automatic cfg_t mk_cfg(int d, int s, int h, int r, int l);
		cfg_t c;
		c.delay_ticks = 16'(d);
		c.strobe_high_ticks = 16'(s);
		c.hold_wait_ticks = 16'(h);
		c.reset_wait_ticks = 16'(r);
		c.retry_limit = 8'(l);
		return c;
	endfunction

	function automatic logic [15:0] reg_field(cfg_t c, logic [2:0] idx);
		case (idx)
			REG_DELAY:       return c.delay_ticks;
			REG_STROBE_HIGH: return c.strobe_high_ticks;
			REG_HOLD_WAIT:   return c.hold_wait_ticks;
			REG_RESET_WAIT:  return c.reset_wait_ticks;
			default:         return {8'h00, c.retry_limit};
		endcase
	endfunction

	// mostly well-formed traffic: ticks with the odd state change or reset
	// request, some undefined commands and states mixed in as noise
	function automatic void pick_item(input int hold_pct, output logic [1:0] cmd,
			output logic [7:0] data);
		int         r;
		logic [2:0] req;
		r = $urandom_range(0, 99);
		if (r < 84)
			cmd = CMD_TICK;
		else if (r < 91)
			cmd = CMD_SET;
		else if (r < 98)
			cmd = CMD_RESET;
		else
			cmd = CMD_NONE;
		if ($urandom_range(0, 1))
			req = ST_UP;
		else
			req = 3'($urandom_range(0, 7));
		data = pack_cmd($urandom_range(0, 99) < hold_pct, req, 1'($urandom_range(0, 1)),
			$urandom_range(0, 99) < 85);
	endfunction

	// offer one command transaction, with a random gap first unless quiet;
	// tvalid stays high into the next call so back-to-back items need no toggle
	task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < send_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, data);
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// write all five registers; only called while the core is idle
	task automatic program_config(input cfg_t c);
		for (int idx = 0; idx <= int'(REG_RETRY_LIMIT); idx++) begin
			cfg_we <= 1'b1;
			cfg_addr <= 3'(idx);
			cfg_wdata <= reg_field(c, 3'(idx));
			@(posedge clk);
			sb.write_reg(3'(idx), reg_field(c, 3'(idx)));
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(input cfg_t c, input int n_items, input int hold_pct,
			input int s_pct, input int r_pct, input bit squeeze);
		logic [1:0] cmd;
		logic [7:0] data;
		settle();
		program_config(c);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < n_items; i++) begin
			// long receiver hold-off while commands keep coming, to fill the core
			if (squeeze && i == n_items / 4)
				long_holdoff_req = 1'b1;
			pick_item(hold_pct, cmd, data);
			send_cmd(cmd, data);
		end
	endtask

	// result side: check each accepted result, then pick next cycle's tready
	initial begin : result_sink
		int stall_left;
		bit next_ready;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_output(m_tdata);
			if (long_holdoff_req) begin
				long_holdoff_req = 1'b0;
				stall_left = LONG_HOLDOFF;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < recv_idle_pct) begin
				stall_left = $urandom_range(1, 6);
			end
			if (stall_left > 0) begin
				next_ready = 1'b0;
				stall_left--;
			end else begin
				next_ready = arst_n;
			end
			m_tready <= next_ready;
		end
	end

	// watchdog on progress
	initial begin : stall_watch
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no transaction for %0d cycles", STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short waits so every branch is reached in a few ticks
		send_idle_pct = 20;
		recv_idle_pct = 20;
		program_config(mk_cfg(1, 1, 2, 2, 1));
		send_cmd(CMD_TICK, pack_cmd(1'b0, ST_INITIAL, 1'b0, 1'b1));  // tick while initial
		send_cmd(CMD_NONE, pack_cmd(1'b1, 3'd7, 1'b1, 1'b1));        // undefined command
		send_cmd(CMD_RESET, pack_cmd(1'b0, ST_IDLE, 1'b1, 1'b1));    // refused, not idle
		send_cmd(CMD_SET, pack_cmd(1'b0, 3'd5, 1'b0, 1'b0));         // undefined state
		send_cmd(CMD_SET, pack_cmd(1'b0, ST_UP, 1'b0, 1'b0));
		// power-up with hold low: timeout on the first retry, then idle
		repeat (6) send_cmd(CMD_TICK, pack_cmd(1'b0, ST_INITIAL, 1'b0, 1'b0));
		send_cmd(CMD_RESET, pack_cmd(1'b0, ST_INITIAL, 1'b1, 1'b0)); // refused, main power off
		send_cmd(CMD_RESET, pack_cmd(1'b0, ST_INITIAL, 1'b1, 1'b1)); // minimum-system reset
		// reset sequence back into power-up, boot pin high
		repeat (6) send_cmd(CMD_TICK, pack_cmd(1'b0, ST_INITIAL, 1'b0, 1'b0));
		// power-up that sees hold high
		repeat (5) send_cmd(CMD_TICK, pack_cmd(1'b1, ST_INITIAL, 1'b0, 1'b0));
		send_cmd(CMD_SET, pack_cmd(1'b0, ST_DOWN, 1'b0, 1'b0));
		send_cmd(CMD_TICK, pack_cmd(1'b1, ST_INITIAL, 1'b0, 1'b0));

		// random: defaults, then small random settings, then the extremes
		run_phase(mk_cfg(5, 3, 100, 400, 3), 150, 3, 25, 25, 1'b0);
		for (int p = 0; p < 4; p++) begin
			run_phase(mk_cfg($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 6),
				$urandom_range(0, 10), $urandom_range(1, 4)), 230, $urandom_range(5, 60),
				(p == 1) ? 0 : 20, (p == 2) ? 0 : 25, p == 1);
		end
		run_phase(mk_cfg(0, 0, 0, 0, 1), 120, 30, 20, 20, 1'b0);
		run_phase(mk_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255), 60, 30, 20, 20, 1'b0);
		run_phase(mk_cfg(16'hFFFF, 0, 16'hFFFF, 0, 1), 60, 30, 20, 20, 1'b0);

		// last part without any idling on either side
		settle();
		quiet = 1'b1;
		run_phase(mk_cfg($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4),
			$urandom_range(0, 6), $urandom_range(1, 3)), 200, 25, 0, 0, 1'b0);

		settle();
		repeat (4) @(posedge clk);
		$display("sent %0d commands under %0d register settings, checked %0d results",
			sb.n_sent, n_settings, sb.n_checked);
		$display("saw %0d hold timeouts, %0d power-up completions, %0d reset requests taken",
			sb.n_timeouts, sb.n_irq, sb.n_resets_taken);
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/psq_pkg.sv
src/psq_cfg_regs.sv
src/psq_step.sv
src/pmic_power_sequencer_core.sv
tb/sv/psq_tb_pkg.sv
tb/sv/tb_top.sv
